[hdl/bmc_pkg.sv]
// Package for the bracket match checker: status codes and opener characters.
// Depends on nothing; used by the top level, its assertion checker and the testbench.

package bmc_pkg;

   // Status codes that go out with each response.
   typedef logic [2:0] status_type;

   localparam status_type ST_PUSHED   = 3'd0;
   localparam status_type ST_MATCHED  = 3'd1;
   localparam status_type ST_ILLEGAL  = 3'd2;
   localparam status_type ST_OVERFLOW = 3'd3;
   localparam status_type ST_IGNORED  = 3'd4;

   // Opening bracket characters.
   localparam logic [7:0] CH_BRACE   = 8'h7B;
   localparam logic [7:0] CH_PAREN   = 8'h28;
   localparam logic [7:0] CH_BRACKET = 8'h5B;

   // A closer matches when its code lies one or two above the opener's code.
   localparam logic [7:0] MATCH_GAP_NEAR = 8'd1;
   localparam logic [7:0] MATCH_GAP_FAR  = 8'd2;

   function automatic logic is_opener(input logic [7:0] code);
      return (code == CH_BRACE) || (code == CH_PAREN) || (code == CH_BRACKET);
   endfunction

endpackage

[hdl/bracket_match_checker.sv]
// Balanced bracket checker: keeps a stack of openers in an on-chip memory.
// Depends on bmc_pkg for status codes and opener characters.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   req     | in        | req_valid / req_stall | req_start_req, req_char_code
//   rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_depth
//
// One character is taken every cycle while req_stall is low; its response appears in the next cycle.
// The stack top sits in a register and the entry below it is prefetched from
// the memory every cycle, so a pop never waits for the registered read.
// Reset clears the stack count, the error latch and the response valid; the
// memory itself is not cleared, since only written entries are ever used.
// req_stall follows rsp_stall only while a response is held in the output stage.

module bracket_match_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_start_req,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmc_pkg::status_type rsp_status,
   output logic [5:0]          rsp_depth
);
   import bmc_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   logic [7:0]    stack_mem [STACK_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic          error_ff, error_in;
   logic [7:0]    top_ff, top_in;
   logic [7:0]    below_ff;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff, status_in;
   logic [5:0]    rsp_depth_ff;

   logic          accept;
   logic [CW-1:0] count_eff;
   logic          error_eff;
   logic [7:0]    diff;
   logic          do_push, do_pop;
   logic [CW-1:0] below_count;
   logic [AW-1:0] rd_addr;
   logic [CW+5:0] depth_wide;

   // The input moves whenever the output stage is empty or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Decode one character against the current top of stack.
   always_comb begin
      count_eff = req_start_req ? '0 : count_ff;
      error_eff = req_start_req ? 1'b0 : error_ff;
      diff      = req_char_code - top_ff;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      error_in  = error_eff;
      if (error_eff) begin
         status_in = ST_IGNORED;
      end else if (is_opener(req_char_code)) begin
         if (count_eff >= FULL_COUNT) begin
            status_in = ST_OVERFLOW;
         end else begin
            status_in = ST_PUSHED;
            do_push   = 1'b1;
         end
      end else if (count_eff == '0) begin
         status_in = ST_ILLEGAL;
         error_in  = 1'b1;
      end else if ((diff == MATCH_GAP_NEAR) || (diff == MATCH_GAP_FAR)) begin
         status_in = ST_MATCHED;
         do_pop    = 1'b1;
      end else begin
         status_in = ST_ILLEGAL;
         error_in  = 1'b1;
      end
   end

   // Next count and next top of stack.
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (accept) begin
         count_in = count_eff;
         if (do_push) begin
            count_in = count_eff + CW'(1);
            top_in   = req_char_code;
         end else if (do_pop) begin
            count_in = count_eff - CW'(1);
            top_in   = below_ff;
         end
      end
   end

   // Prefetch the entry just below the next top; it meets a write only on a push to depth one.
   assign below_count = (count_in >= CW'(2)) ? (count_in - CW'(2)) : '0;
   assign rd_addr     = below_count[AW-1:0];

   // Stack memory: one write port for pushes, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && do_push) begin
         stack_mem[count_eff[AW-1:0]] <= req_char_code;
      end
      below_ff <= stack_mem[rd_addr];
   end

   // Depth is reported in its low six bits.
   assign depth_wide = {6'b0, count_in};

   // Control state, stack top and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            error_ff     <= error_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      top_ff <= top_in;
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_depth_ff  <= depth_wide[5:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = rsp_depth_ff;

endmodule

[hdl/bmc_checker.sv]
// Assertion checker for the bracket match checker, watching its ports only.
// Depends on bmc_pkg; bound to bracket_match_checker at the end of this file.

module bmc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_start_req,
   input logic [7:0]          req_char_code,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input bmc_pkg::status_type rsp_status,
   input logic [5:0]          rsp_depth
);
   import bmc_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // A held response keeps its contents until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_depth)))
      else $error("response changed while stalled");

   // Every accepted character yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("no response after a request transfer");

   // The input is held back only by a waiting response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A fresh expression starting with an opener pushes it as the only entry.
   a_start_push: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_start_req && is_opener(req_char_code))
      |=> (rsp_status == ST_PUSHED && rsp_depth == 6'd1))
      else $error("start with opener did not push to depth one");

   // A fresh expression starting with a closer is illegal on an empty stack.
   a_start_closer: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_start_req && !is_opener(req_char_code))
      |=> (rsp_status == ST_ILLEGAL && rsp_depth == 6'd0))
      else $error("start with closer was not reported illegal");

endmodule

bind bracket_match_checker bmc_checker u_bmc_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the bracket match checker: a scoreboard class predicts every
// response from the accepted characters. Depends on bmc_pkg and the bracket_match_checker RTL.

module tb;
   import bmc_pkg::*;

   localparam int STACK_DEPTH     = 32;
   localparam int ITEM_TARGET     = 450;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PRESSURE_AFTER  = 150;
   localparam int PRESSURE_CYCLES = 80;
   localparam int SETTLE_CYCLES   = 4;

   typedef struct packed {
      status_type status;
      logic [5:0] depth;
   } outcome_type;

   // Tracks the opener stack and the error latch, and holds the responses still owed.
   class bracket_scoreboard;
      logic [7:0]  opener_stack [STACK_DEPTH];
      int unsigned open_count;
      bit          in_error;
      outcome_type pending [$];
      int unsigned status_tally [5];
      int unsigned char_count;
      int unsigned live_count;
      int unsigned checked_count;
      int unsigned error_count;
      int unsigned deepest;

      // Works out the response to one accepted character.
      function void note_char(logic start, logic [7:0] code);
         outcome_type want;
         logic [7:0]  gap;
         if (start) begin
            open_count = 0;
            in_error   = 1'b0;
         end
         if (in_error) begin
            want.status = ST_IGNORED;
         end else if (code == CH_BRACE || code == CH_PAREN || code == CH_BRACKET) begin
            if (open_count >= STACK_DEPTH) begin
               want.status = ST_OVERFLOW;
            end else begin
               opener_stack[open_count] = code;
               open_count++;
               want.status = ST_PUSHED;
            end
         end else if (open_count == 0) begin
            in_error    = 1'b1;
            want.status = ST_ILLEGAL;
         end else begin
            gap = code - opener_stack[open_count - 1];
            if (gap == MATCH_GAP_NEAR || gap == MATCH_GAP_FAR) begin
               open_count--;
               want.status = ST_MATCHED;
            end else begin
               in_error    = 1'b1;
               want.status = ST_ILLEGAL;
            end
         end
         want.depth = open_count[5:0];
         pending.push_back(want);
         status_tally[want.status]++;
         char_count++;
         if (want.status != ST_IGNORED) live_count++;
         if (open_count > deepest) deepest = open_count;
      endfunction

      // Compares one response transfer with the oldest outstanding prediction.
      function void check_result(status_type status, logic [5:0] depth);
         outcome_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: status %0d depth %0d", status, depth);
            error_count++;
            return;
         end
         want = pending.pop_front();
         checked_count++;
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            error_count++;
         end
         if (depth !== want.depth) begin
            $error("depth mismatch: expected %0d, actual %0d", want.depth, depth);
            error_count++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_start_req;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_stall;
   status_type  rsp_status;
   logic [5:0]  rsp_depth;
   int unsigned cycle_count;
   bit          tx_burst;

   bracket_scoreboard sb = new();

   bracket_match_checker #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_depth     (rsp_depth)
   );

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, sb.pending.size());
         $display("[bracket_match_checker] ERROR");
         $finish;
      end
   end

   // Every response transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_status, rsp_depth);
   end

   // Response side stalls at random, and once holds off long enough to back up the input.
   initial begin
      int unsigned pick;
      int unsigned span;
      bit          pressure_done;
      rsp_stall <= 1'b0;
      pressure_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && sb.checked_count >= PRESSURE_AFTER) begin
            rsp_stall <= 1'b1;
            span = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 4);
            end else if (pick < 55) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(20, 60);
            end else if (pick < 90) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               span = $urandom_range(8, 25);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   // Idle cycles before the next character: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (tx_burst || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_opener();
      case ($urandom_range(0, 2))
         0: return CH_PAREN;
         1: return CH_BRACKET;
         default: return CH_BRACE;
      endcase
   endfunction

   // Offers one character and waits for its transfer. Called at a rising edge.
   task automatic send_char(input logic start, input logic [7:0] code);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      sb.note_char(start, code);
   endtask

   // Sends a well-formed expression with random brackets. A deep one pushes every opener
   // first and may run past the stack top. A spoiled one has a random byte at a random
   // point, followed by a few random trailing characters.
   task automatic send_expression(input int unsigned pairs, input bit deep, input bit spoil,
                                  input bit fresh);
      logic [7:0]  shadow [$];
      logic [7:0]  code;
      int unsigned opens_left;
      int unsigned sent;
      int unsigned spoil_at;
      bit          do_open;
      opens_left = pairs;
      sent = 0;
      spoil_at = spoil ? $urandom_range(0, 2 * pairs - 1) : 32'hFFFF_FFFF;
      while (opens_left > 0 || shadow.size() > 0) begin
         if (sent == spoil_at) begin
            send_char(sent == 0 && fresh, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) send_char(1'b0, 8'($urandom_range(0, 255)));
            return;
         end
         if (opens_left == 0) do_open = 1'b0;
         else if (shadow.size() == 0 || deep) do_open = 1'b1;
         else do_open = $urandom_range(0, 1);
         if (do_open) begin
            code = pick_opener();
            if (shadow.size() < STACK_DEPTH) shadow.push_back(code);
            opens_left--;
         end else begin
            code = shadow.pop_back() + 8'($urandom_range(1, 2));
         end
         send_char(sent == 0 && fresh, code);
         sent++;
      end
   endtask

   // Random bytes, half of them chosen as openers, with an occasional start.
   task automatic send_noise(input int unsigned count);
      logic [7:0] code;
      repeat (count) begin
         code = $urandom_range(0, 1) ? pick_opener() : 8'($urandom_range(0, 255));
         send_char($urandom_range(0, 7) == 0, code);
      end
   endtask

   // Reset, directed characters, random expressions, then drain and report.
   initial begin
      int unsigned pick;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_start_req <= 1'b0;
      req_char_code <= 8'h00;
      tx_burst = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Each opener with a matching closer, using both closer offsets, nested and flat.
      send_char(1'b1, CH_PAREN);
      send_char(1'b0, CH_PAREN + MATCH_GAP_NEAR);
      send_char(1'b0, CH_BRACKET);
      send_char(1'b0, CH_BRACE);
      send_char(1'b0, CH_BRACE + MATCH_GAP_FAR);
      send_char(1'b0, CH_BRACKET + MATCH_GAP_FAR);
      send_char(1'b0, CH_BRACE);
      send_char(1'b0, CH_BRACE + MATCH_GAP_NEAR);
      // Closer on an empty stack, then characters ignored while the latch is set.
      send_char(1'b0, CH_PAREN + MATCH_GAP_FAR);
      send_char(1'b0, CH_PAREN);
      send_char(1'b0, 8'hFF);
      // Start clears the latch; byte zero is an ordinary closer and the stack is empty.
      send_char(1'b1, 8'h00);
      // Wrong closer over an opener keeps the depth.
      send_char(1'b1, CH_BRACKET);
      send_char(1'b0, 8'hFF);
      // Start empties a non-empty stack before its own character.
      send_char(1'b1, CH_PAREN);
      send_char(1'b1, 8'h80);
      send_char(1'b1, CH_BRACE);
      send_char(1'b0, CH_BRACKET + MATCH_GAP_FAR);
      send_char(1'b1, CH_PAREN);
      send_char(1'b0, CH_PAREN);
      send_char(1'b0, 8'h00);

      // Fill the stack past its top so pushes are dropped, then unwind it.
      send_expression(STACK_DEPTH + 2, 1'b1, 1'b0, 1'b1);

      // Random mix: mostly well-formed expressions, some spoiled ones and some noise.
      while (sb.char_count < ITEM_TARGET) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8)
            send_expression($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3), 1'b1, 1'b0,
                            $urandom_range(0, 3) != 0);
         else if (pick < 70)
            send_expression($urandom_range(1, 8), 1'b0, 1'b0, $urandom_range(0, 3) != 0);
         else if (pick < 85)
            send_expression($urandom_range(1, 8), 1'b0, 1'b1, 1'b1);
         else
            send_noise($urandom_range(1, 6));
      end
      req_valid <= 1'b0;

      // Drain the outstanding responses, then leave room for anything unexpected.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run sent %0d characters (%0d not ignored), checked %0d responses, %s%0d.",
               sb.char_count, sb.live_count, sb.checked_count, "deepest stack ",
               sb.deepest);
      $display("Outcomes: pushed %0d, matched %0d, illegal %0d, overflow %0d, ignored %0d.",
               sb.status_tally[ST_PUSHED], sb.status_tally[ST_MATCHED],
               sb.status_tally[ST_ILLEGAL], sb.status_tally[ST_OVERFLOW],
               sb.status_tally[ST_IGNORED]);
      if (sb.error_count == 0 && sb.pending.size() == 0) begin
         $display("[bracket_match_checker] OK");
      end else begin
         $display("[bracket_match_checker] ERROR");
      end
      $finish;
   end

endmodule
